// ===== hdl/bmf_pkg.sv =====
// Shared types, widths, constants and helper functions of the F-measure unit.
`default_nettype none
package bmf_pkg;

	// Counter widths
	localparam int IMAGE_COUNT_WIDTH = 24;
	localparam int BATCH_COUNT_WIDTH = 32;
	localparam int CUR_W = (IMAGE_COUNT_WIDTH > BATCH_COUNT_WIDTH) ?
		IMAGE_COUNT_WIDTH : BATCH_COUNT_WIDTH;
	localparam int SUM_W = CUR_W + 1;
	localparam int OUT_CNT_W = 32;
	localparam int CAP_W = (CUR_W > OUT_CNT_W) ? CUR_W : OUT_CNT_W;

	// Divider widths: denominators reach 2*tp + fp + fn
	localparam int DIV_W = CUR_W + 2;
	localparam int Q_W = 17;

	// Pixel stream
	localparam int PIXEL_W = 8;
	localparam logic [PIXEL_W-1:0] TRUTH_POSITIVE = 8'd255;
	localparam logic [PIXEL_W-1:0] THRESHOLD_RESET = 8'd127;
	localparam int IN_DATA_W = 2 * PIXEL_W;

	// Result word
	localparam int OUT_RAW_W = 4 * OUT_CNT_W + 3 * Q_W + 3;
	localparam int OUT_DATA_W = ((OUT_RAW_W + 7) / 8) * 8;

	// Configuration port
	localparam int ADDR_W = 3;
	localparam logic [ADDR_W-1:0] ADDR_THRESHOLD = 3'd0;
	localparam int APB_DATA_W = 32;

	// Counter slots
	localparam int NUM_CNT = 4;
	localparam int CNT_TP = 0;
	localparam int CNT_FP = 1;
	localparam int CNT_FN = 2;
	localparam int CNT_TN = 3;

	// Job queue between front and back
	localparam int QUEUE_DEPTH = 4;
	localparam int QPTR_W = $clog2(QUEUE_DEPTH);

	typedef logic [NUM_CNT-1:0][IMAGE_COUNT_WIDTH-1:0] image_cnt_t;

	typedef struct packed {
		logic batch_end;
		image_cnt_t cnt;
	} job_t;

	// Clip a count to the 32-bit output field
	function automatic logic [OUT_CNT_W-1:0] cap_count(input logic [CUR_W-1:0] x);
		logic [CAP_W-1:0] ext;
		ext = CAP_W'(x);
		if (ext > CAP_W'({OUT_CNT_W{1'b1}}))
			return '1;
		return ext[OUT_CNT_W-1:0];
	endfunction

	// Add an image count into a batch count, saturating at full scale
	function automatic logic [BATCH_COUNT_WIDTH-1:0] batch_add(
		input logic [BATCH_COUNT_WIDTH-1:0] b,
		input logic [IMAGE_COUNT_WIDTH-1:0] i
	);
		logic [SUM_W-1:0] sum;
		sum = SUM_W'(b) + SUM_W'(i);
		if (sum > SUM_W'({BATCH_COUNT_WIDTH{1'b1}}))
			return '1;
		return sum[BATCH_COUNT_WIDTH-1:0];
	endfunction

endpackage
`default_nettype wire

// ===== hdl/bmf_front.sv =====
// Front end: binarizes pixel pairs, keeps image counts, queues a job per image end.
`default_nettype none
module bmf_front (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic [bmf_pkg::PIXEL_W-1:0]   threshold,
	input  wire logic                          in_valid,
	output logic                               in_ready,
	input  wire logic [bmf_pkg::PIXEL_W-1:0]   detected_pixel,
	input  wire logic [bmf_pkg::PIXEL_W-1:0]   truth_pixel,
	input  wire logic                          image_end,
	input  wire logic                          batch_end,
	input  wire logic                          queue_full,
	output logic                               push,
	output bmf_pkg::job_t                      push_job
);
	import bmf_pkg::*;

	image_cnt_t cnt_q;
	image_cnt_t cnt_next;
	logic       accept;
	logic       match;
	logic       positive;
	logic [1:0] slot;

	assign in_ready = !queue_full;
	assign accept   = in_valid && in_ready;

	// Classify the pixel pair
	assign match    = (detected_pixel > threshold) == (truth_pixel > threshold);
	assign positive = (truth_pixel == TRUTH_POSITIVE);

	always_comb begin
		priority if (positive && match) begin
			slot = 2'(CNT_TP);
		end else if (positive) begin
			slot = 2'(CNT_FN);
		end else if (match) begin
			slot = 2'(CNT_TN);
		end else begin
			slot = 2'(CNT_FP);
		end
	end

	// Saturating increment of the selected counter
	always_comb begin
		for (int k = 0; k < NUM_CNT; k++) begin
			if (slot == 2'(k) && cnt_q[k] != '1)
				cnt_next[k] = cnt_q[k] + IMAGE_COUNT_WIDTH'(1);
			else
				cnt_next[k] = cnt_q[k];
		end
	end

	// Hand the finished image to the back end
	assign push               = accept && (image_end || batch_end);
	assign push_job.batch_end = batch_end;
	assign push_job.cnt       = cnt_next;

	// Advance counts; clear after an image end
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (accept) begin
			if (image_end || batch_end)
				cnt_q <= '0;
			else
				cnt_q <= cnt_next;
		end
	end

endmodule
`default_nettype wire

// ===== hdl/bmf_queue.sv =====
// Small job queue between the pixel front end and the ratio back end.
`default_nettype none
module bmf_queue (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            push,
	input  wire bmf_pkg::job_t   push_job,
	output logic                 full,
	input  wire logic            pop,
	output bmf_pkg::job_t        head,
	output logic                 not_empty
);
	import bmf_pkg::*;

	job_t              mem_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QPTR_W:0]   count_q;
	logic              do_push;
	logic              do_pop;

	assign full      = (count_q == (QPTR_W + 1)'(QUEUE_DEPTH));
	assign not_empty = (count_q != '0);
	assign head      = mem_q[rd_ptr_q];
	assign do_push   = push && !full;
	assign do_pop    = pop && not_empty;

	// Store pushed jobs
	always_ff @(posedge clk) begin
		if (do_push)
			mem_q[wr_ptr_q] <= push_job;
	end

	// Advance pointers and fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push)
				wr_ptr_q <= wr_ptr_q + QPTR_W'(1);
			if (do_pop)
				rd_ptr_q <= rd_ptr_q + QPTR_W'(1);
			if (do_push && !do_pop)
				count_q <= count_q + (QPTR_W + 1)'(1);
			else if (do_pop && !do_push)
				count_q <= count_q - (QPTR_W + 1)'(1);
		end
	end

endmodule
`default_nettype wire

// ===== hdl/bmf_div.sv =====
// Restoring divider: one quotient bit per cycle, Q1.16 result rounded half up.
`default_nettype none
module bmf_div (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         start,
	input  wire logic [bmf_pkg::DIV_W-1:0]    num,
	input  wire logic [bmf_pkg::DIV_W-1:0]    den,
	output logic                              done,
	output logic [bmf_pkg::Q_W-1:0]           quo
);
	import bmf_pkg::*;

	localparam int CNT_W = $clog2(Q_W);

	logic [DIV_W-1:0] rem_q;
	logic [DIV_W-1:0] den_q;
	logic [Q_W-1:0]   q_q;
	logic [CNT_W-1:0] step_q;
	logic             busy_q;
	logic             done_q;
	logic [DIV_W:0]   rem_shift;
	logic             fits;
	logic [DIV_W:0]   rem_diff;

	// One step: shift, compare, subtract
	assign rem_shift = {rem_q, 1'b0};
	assign fits      = rem_shift >= {1'b0, den_q};
	assign rem_diff  = rem_shift - {1'b0, den_q};

	// Round the extra quotient bit away
	assign quo  = Q_W'((Q_W + 1)'(q_q) + (Q_W + 1)'(1) >> 1);
	assign done = done_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rem_q  <= '0;
			den_q  <= '0;
			q_q    <= '0;
			step_q <= '0;
			busy_q <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				rem_q  <= num;
				den_q  <= den;
				q_q    <= '0;
				step_q <= '0;
				busy_q <= 1'b1;
			end else if (busy_q) begin
				rem_q <= fits ? rem_diff[DIV_W-1:0] : rem_shift[DIV_W-1:0];
				q_q   <= {q_q[Q_W-2:0], fits};
				if (step_q == CNT_W'(Q_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end else begin
					step_q <= step_q + CNT_W'(1);
				end
			end
		end
	end

endmodule
`default_nettype wire

// ===== hdl/bmf_back.sv =====
// Back end: folds image counts into the batch, computes the ratios, drives results.
`default_nettype none
module bmf_back (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	input  wire logic                             job_valid,
	input  wire bmf_pkg::job_t                    job,
	output logic                                  pop,
	output logic                                  m_tvalid,
	input  wire logic                             m_tready,
	output logic [bmf_pkg::OUT_DATA_W-1:0]        m_tdata,
	output logic                                  m_tlast,
	output logic                                  m_tuser
);
	import bmf_pkg::*;

	typedef enum logic [1:0] {
		S_IDLE,
		S_SETUP,
		S_WAIT,
		S_EMIT
	} state_t;

	typedef enum logic [1:0] {
		R_PREC,
		R_REC,
		R_F
	} ratio_t;

	state_t                                     state_q;
	ratio_t                                     rsel_q;
	logic [NUM_CNT-1:0][CUR_W-1:0]              cur_q;
	logic [NUM_CNT-1:0][BATCH_COUNT_WIDTH-1:0]  batch_q;
	logic                                       bat_end_q;
	logic                                       overall_q;
	logic [2:0][Q_W-1:0]                        res_q;
	logic [2:0]                                 ok_q;
	logic                                       m_tvalid_q;
	logic [OUT_DATA_W-1:0]                      m_tdata_q;
	logic                                       m_tlast_q;
	logic                                       m_tuser_q;

	logic [DIV_W-1:0] tp_x;
	logic [DIV_W-1:0] fp_x;
	logic [DIV_W-1:0] fn_x;
	logic [DIV_W-1:0] num;
	logic [DIV_W-1:0] den;
	logic             ratio_ok;
	logic             div_start;
	logic             div_done;
	logic [Q_W-1:0]   div_quo;
	logic             out_free;
	logic [OUT_RAW_W-1:0] result_word;

	assign tp_x = DIV_W'(cur_q[CNT_TP]);
	assign fp_x = DIV_W'(cur_q[CNT_FP]);
	assign fn_x = DIV_W'(cur_q[CNT_FN]);

	// Pick numerator and divisor of the current ratio
	always_comb begin
		unique case (rsel_q)
			R_PREC: begin
				num      = tp_x;
				den      = tp_x + fp_x;
				ratio_ok = (den != '0);
			end
			R_REC: begin
				num      = tp_x;
				den      = tp_x + fn_x;
				ratio_ok = (den != '0);
			end
			R_F: begin
				num      = tp_x << 1;
				den      = (tp_x << 1) + fp_x + fn_x;
				ratio_ok = (tp_x != '0);
			end
			default: begin
				num      = '0;
				den      = '0;
				ratio_ok = 1'b0;
			end
		endcase
	end

	assign div_start = (state_q == S_SETUP) && ratio_ok;
	assign pop       = (state_q == S_IDLE) && job_valid;
	assign out_free  = !m_tvalid_q || m_tready;

	bmf_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.num    (num),
		.den    (den),
		.done   (div_done),
		.quo    (div_quo)
	);

	// Result word, listed from the highest field down
	assign result_word = {
		ok_q[R_F], ok_q[R_REC], ok_q[R_PREC],
		res_q[R_F], res_q[R_REC], res_q[R_PREC],
		cap_count(cur_q[CNT_TN]), cap_count(cur_q[CNT_FN]),
		cap_count(cur_q[CNT_FP]), cap_count(cur_q[CNT_TP])
	};

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;
	assign m_tlast  = m_tlast_q;
	assign m_tuser  = m_tuser_q;

	// Sequencer with batch counts and the output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			rsel_q     <= R_PREC;
			cur_q      <= '0;
			batch_q    <= '0;
			bat_end_q  <= 1'b0;
			overall_q  <= 1'b0;
			res_q      <= '0;
			ok_q       <= '0;
			m_tvalid_q <= 1'b0;
			m_tdata_q  <= '0;
			m_tlast_q  <= 1'b0;
			m_tuser_q  <= 1'b0;
		end else begin
			if (m_tvalid_q && m_tready)
				m_tvalid_q <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					if (job_valid) begin
						for (int k = 0; k < NUM_CNT; k++) begin
							cur_q[k]   <= CUR_W'(job.cnt[k]);
							batch_q[k] <= batch_add(batch_q[k], job.cnt[k]);
						end
						bat_end_q <= job.batch_end;
						overall_q <= 1'b0;
						rsel_q    <= R_PREC;
						state_q   <= S_SETUP;
					end
				end
				S_SETUP: begin
					ok_q[rsel_q] <= ratio_ok;
					if (ratio_ok) begin
						state_q <= S_WAIT;
					end else begin
						res_q[rsel_q] <= '0;
						if (rsel_q == R_F) begin
							state_q <= S_EMIT;
						end else begin
							rsel_q <= ratio_t'(rsel_q + 2'd1);
						end
					end
				end
				S_WAIT: begin
					if (div_done) begin
						res_q[rsel_q] <= div_quo;
						if (rsel_q == R_F) begin
							state_q <= S_EMIT;
						end else begin
							rsel_q  <= ratio_t'(rsel_q + 2'd1);
							state_q <= S_SETUP;
						end
					end
				end
				S_EMIT: begin
					if (out_free) begin
						m_tvalid_q <= 1'b1;
						m_tdata_q  <= OUT_DATA_W'(result_word);
						m_tuser_q  <= overall_q;
						m_tlast_q  <= overall_q || !bat_end_q;
						if (!overall_q && bat_end_q) begin
							for (int k = 0; k < NUM_CNT; k++)
								cur_q[k] <= CUR_W'(batch_q[k]);
							batch_q   <= '0;
							overall_q <= 1'b1;
							rsel_q    <= R_PREC;
							state_q   <= S_SETUP;
						end else begin
							state_q <= S_IDLE;
						end
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

endmodule
`default_nettype wire

// ===== hdl/binary_map_f_measure_unit.sv =====
// Top level of the binary map F-measure unit: stream ports, register port, front and back.
//
// Input stream (s_*): one word per detector/truth pixel pair. tdata holds
// detected_pixel [7:0] and truth_pixel [15:8]; tlast marks the last pixel of
// an image and tuser the last pixel of the batch (which also ends the image).
// The front end takes one word per cycle while the job queue is not full, classifies it
// combinationally and counts it into per-image true/false positive/negative totals.
// Each image end queues a job (four entries deep) for the back end, which
// folds the counts into the batch totals and computes precision, recall and
// F-measure through one shared 17-step restoring divider, one quotient bit
// per cycle. Each result word takes up to three divisions plus setup and output;
// a batch end adds a second result word; no new job is taken until the last is registered.
// s_tready drops only while the job queue is full, i.e. when image ends come
// closer than the back end drains them. The result register holds a word
// while m_tready is low; the back end keeps working until it needs that
// register again. Reset clears all counts and sets the threshold to 127.
// Register at byte address 0: binary_threshold (8 bits).
`default_nettype none
module binary_map_f_measure_unit (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	// APB register port
	input  wire logic                              psel,
	input  wire logic                              penable,
	input  wire logic                              pwrite,
	input  wire logic [bmf_pkg::ADDR_W-1:0]        paddr,
	input  wire logic [bmf_pkg::APB_DATA_W-1:0]    pwdata,
	output logic [bmf_pkg::APB_DATA_W-1:0]         prdata,
	output logic                                   pready,
	// Pixel stream
	input  wire logic                              s_tvalid,
	output logic                                   s_tready,
	// detected_pixel [7:0], truth_pixel [15:8]
	input  wire logic [bmf_pkg::IN_DATA_W-1:0]     s_tdata,
	input  wire logic                              s_tlast,   // image_end
	input  wire logic                              s_tuser,   // batch_end
	// Result stream
	output logic                                   m_tvalid,
	input  wire logic                              m_tready,
	// true_pos [31:0], false_pos [63:32], false_neg [95:64], true_neg [127:96],
	// precision [144:128], recall [161:145], f_measure [178:162],
	// precision_ok [179], recall_ok [180], f_ok [181], zero [183:182]
	output logic [bmf_pkg::OUT_DATA_W-1:0]         m_tdata,
	output logic                                   m_tlast,   // last_result
	output logic                                   m_tuser    // is_overall
);
	import bmf_pkg::*;

	logic [PIXEL_W-1:0] threshold_q;
	logic               cfg_write;
	logic               queue_full;
	logic               push;
	job_t               push_job;
	logic               pop;
	job_t               head;
	logic               not_empty;

	// Register port
	assign pready    = 1'b1;
	assign cfg_write = psel && penable && pwrite && pready && (paddr == ADDR_THRESHOLD);
	assign prdata    = (paddr == ADDR_THRESHOLD) ? APB_DATA_W'(threshold_q) : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			threshold_q <= THRESHOLD_RESET;
		end else if (cfg_write) begin
			threshold_q <= pwdata[PIXEL_W-1:0];
		end
	end

	bmf_front u_front (
		.clk            (clk),
		.arst_n         (arst_n),
		.threshold      (threshold_q),
		.in_valid       (s_tvalid),
		.in_ready       (s_tready),
		.detected_pixel (s_tdata[PIXEL_W-1:0]),
		.truth_pixel    (s_tdata[2*PIXEL_W-1:PIXEL_W]),
		.image_end      (s_tlast),
		.batch_end      (s_tuser),
		.queue_full     (queue_full),
		.push           (push),
		.push_job       (push_job)
	);

	bmf_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_job  (push_job),
		.full      (queue_full),
		.pop       (pop),
		.head      (head),
		.not_empty (not_empty)
	);

	bmf_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.job_valid (not_empty),
		.job       (head),
		.pop       (pop),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tlast   (m_tlast),
		.m_tuser   (m_tuser)
	);

endmodule
`default_nettype wire

// ===== tb/tb_top.sv =====
// Self-checking testbench of the binary map F-measure unit: pixel stream in, score words out.
`timescale 1ns / 100ps
`default_nettype none
module tb_top;
	import bmf_pkg::*;

	localparam int NUM_DIR        = 21;
	localparam int NUM_PHASES     = 8;
	localparam int PHASE_WORDS    = 75;
	localparam int PAUSE_AT       = 37;
	localparam int SETTLE_CYCLES  = 150;
	localparam int TAIL_CYCLES    = 300;
	localparam int CYCLE_LIMIT    = 1000000;
	localparam int HEAVY_IDLE_PCT = 61;
	localparam int LIGHT_IDLE_PCT = 15;

	typedef enum int {IDLE_NONE, IDLE_SEND, IDLE_RECV, IDLE_BOTH} idle_mode_t;

	// One score word as it leaves the block
	typedef struct packed {
		logic        is_overall;
		logic        last_result;
		logic [31:0] tp;
		logic [31:0] fp;
		logic [31:0] fn;
		logic [31:0] tn;
		logic [16:0] prec;
		logic [16:0] rec;
		logic [16:0] fm;
		logic        prec_ok;
		logic        rec_ok;
		logic        f_ok;
	} score_t;

	// Directed pixel, optional threshold change before it, optional typed-in score
	typedef struct packed {
		int set_thr;
		int thr_val;
		int det;
		int tru;
		int img_end;
		int bat_end;
		int typed;
		int tp;
		int fp;
		int fn;
		int tn;
		int prec;
		int rec;
		int fm;
		int pok;
		int rok;
		int fok;
	} dir_row_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic psel = 1'b0;
	logic penable = 1'b0;
	logic pwrite = 1'b0;
	logic [ADDR_W-1:0] paddr = '0;
	logic [APB_DATA_W-1:0] pwdata = '0;
	logic [APB_DATA_W-1:0] prdata;
	logic pready;
	logic s_tvalid = 1'b0;
	logic s_tready;
	// detected_pixel [7:0], truth_pixel [15:8]
	logic [IN_DATA_W-1:0] s_tdata = '0;
	logic s_tlast = 1'b0;   // image_end
	logic s_tuser = 1'b0;   // batch_end
	logic m_tvalid;
	logic m_tready = 1'b0;
	// true_pos [31:0], false_pos [63:32], false_neg [95:64], true_neg [127:96],
	// precision [144:128], recall [161:145], f_measure [178:162],
	// precision_ok [179], recall_ok [180], f_ok [181], zero [183:182]
	logic [OUT_DATA_W-1:0] m_tdata;
	logic m_tlast;   // last_result
	logic m_tuser;   // is_overall

	idle_mode_t idle_mode = IDLE_NONE;
	int err_count = 0;
	int cycle_count = 0;
	score_t expected_scores [$];
	score_t got_score;
	score_t want_score;
	dir_row_t dir_rows [NUM_DIR];

	// Predictor state
	logic [7:0] thr_cfg = THRESHOLD_RESET;
	logic [IMAGE_COUNT_WIDTH-1:0] img_cnt [NUM_CNT] = '{default: '0};
	logic [BATCH_COUNT_WIDTH-1:0] bat_cnt [NUM_CNT] = '{default: '0};

	binary_map_f_measure_unit i_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.psel     (psel),
		.penable  (penable),
		.pwrite   (pwrite),
		.paddr    (paddr),
		.pwdata   (pwdata),
		.prdata   (prdata),
		.pready   (pready),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tlast  (s_tlast),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast),
		.m_tuser  (m_tuser)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	function automatic int idle_pct(idle_mode_t m, logic sender);
		unique case (m)
			IDLE_SEND: return sender ? HEAVY_IDLE_PCT : 0;
			IDLE_RECV: return sender ? 0 : HEAVY_IDLE_PCT;
			IDLE_BOTH: return LIGHT_IDLE_PCT;
			default:   return 0;
		endcase
	endfunction

	// Round-half-up of n * 2^16 / d by a 17-step restoring division
	function automatic logic [16:0] q16_frac(logic [63:0] n, logic [63:0] d);
		logic [63:0] r;
		logic [63:0] q;
		r = n;
		q = '0;
		for (int i = 0; i < 17; i++) begin
			r = r << 1;
			q = q << 1;
			if (r >= d) begin
				r = r - d;
				q = q | 64'd1;
			end
		end
		q = (q + 64'd1) >> 1;
		return q[16:0];
	endfunction

	function automatic score_t make_score(logic ov, logic last, logic [63:0] tp,
			logic [63:0] fp, logic [63:0] fn, logic [63:0] tn);
		score_t s;
		logic [63:0] dp;
		logic [63:0] dr;
		logic [63:0] df;
		dp = tp + fp;
		dr = tp + fn;
		df = 2 * tp + fp + fn;
		s.is_overall  = ov;
		s.last_result = last;
		s.tp = (tp > 64'hFFFF_FFFF) ? '1 : tp[31:0];
		s.fp = (fp > 64'hFFFF_FFFF) ? '1 : fp[31:0];
		s.fn = (fn > 64'hFFFF_FFFF) ? '1 : fn[31:0];
		s.tn = (tn > 64'hFFFF_FFFF) ? '1 : tn[31:0];
		s.prec_ok = (dp != 0);
		s.rec_ok  = (dr != 0);
		s.f_ok    = (tp != 0);
		s.prec = s.prec_ok ? q16_frac(tp, dp) : '0;
		s.rec  = s.rec_ok ? q16_frac(tp, dr) : '0;
		s.fm   = s.f_ok ? q16_frac(2 * tp, df) : '0;
		return s;
	endfunction

	// Classify one pixel pair, fold counts at image and batch ends
	task automatic tally_pixel(input logic [7:0] det, input logic [7:0] tru, input logic ie,
			input logic be, output int n, output score_t img_s, output score_t bat_s);
		logic match;
		int which;
		logic [63:0] sum;
		match = (det > thr_cfg) == (tru > thr_cfg);
		if (tru == TRUTH_POSITIVE)
			which = match ? CNT_TP : CNT_FN;
		else
			which = match ? CNT_TN : CNT_FP;
		if (img_cnt[which] != {IMAGE_COUNT_WIDTH{1'b1}})
			img_cnt[which] = img_cnt[which] + IMAGE_COUNT_WIDTH'(1);
		n = 0;
		img_s = '0;
		bat_s = '0;
		if (!ie && !be)
			return;
		img_s = make_score(1'b0, !be, 64'(img_cnt[CNT_TP]), 64'(img_cnt[CNT_FP]),
			64'(img_cnt[CNT_FN]), 64'(img_cnt[CNT_TN]));
		n = 1;
		for (int k = 0; k < NUM_CNT; k++) begin
			sum = 64'(bat_cnt[k]) + 64'(img_cnt[k]);
			bat_cnt[k] = (sum > 64'({BATCH_COUNT_WIDTH{1'b1}})) ? '1 :
				sum[BATCH_COUNT_WIDTH-1:0];
			img_cnt[k] = '0;
		end
		if (be) begin
			bat_s = make_score(1'b1, 1'b1, 64'(bat_cnt[CNT_TP]), 64'(bat_cnt[CNT_FP]),
				64'(bat_cnt[CNT_FN]), 64'(bat_cnt[CNT_TN]));
			n = 2;
			for (int k = 0; k < NUM_CNT; k++)
				bat_cnt[k] = '0;
		end
	endtask

	task automatic check_field(input string name, input logic [31:0] want_v,
			input logic [31:0] got_v);
		if (want_v !== got_v) begin
			$error("%s: expected %0d, got %0d", name, want_v, got_v);
			err_count++;
		end
	endtask

	// Drop valid and wait until every expected word has come back
	task automatic drain_results();
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (expected_scores.size() != 0)
			@(posedge clk);
	endtask

	task automatic read_threshold(input logic [7:0] want_v);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		paddr   <= ADDR_THRESHOLD;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		check_field("binary_threshold", 32'(want_v), prdata);
		psel    <= 1'b0;
		penable <= 1'b0;
	endtask

	// Write the threshold once the block is idle, then read it back
	task automatic set_threshold(input logic [7:0] value);
		drain_results();
		repeat (SETTLE_CYCLES) @(posedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= ADDR_THRESHOLD;
		pwdata  <= 32'(value);
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		thr_cfg = value;
		@(posedge clk);
		read_threshold(value);
	endtask

	// Offer one pixel word, then record what it should produce
	task automatic send_pixel(input logic [7:0] det, input logic [7:0] tru, input logic ie,
			input logic be, input logic typed, input score_t typed_s);
		int n;
		score_t img_s;
		score_t bat_s;
		while ($urandom_range(99) < idle_pct(idle_mode, 1'b1)) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= {tru, det};
		s_tlast  <= ie;
		s_tuser  <= be;
		do @(posedge clk); while (!s_tready);
		tally_pixel(det, tru, ie, be, n, img_s, bat_s);
		if (typed) begin
			img_s = typed_s;
			img_s.is_overall  = 1'b0;
			img_s.last_result = !be;
			bat_s = typed_s;
			bat_s.is_overall  = 1'b1;
			bat_s.last_result = 1'b1;
		end
		if (n > 0)
			expected_scores.push_back(img_s);
		if (n > 1)
			expected_scores.push_back(bat_s);
	endtask

	// Grey value biased toward the extremes and the threshold
	function automatic logic [7:0] pick_grey(int thr, logic truth);
		int r;
		int v;
		r = $urandom_range(99);
		v = thr + int'($urandom_range(4)) - 2;
		if (v < 0)
			v = 0;
		if (v > 255)
			v = 255;
		if (r < (truth ? 40 : 20))
			return 8'd255;
		if (r < (truth ? 50 : 40))
			return 8'd0;
		if (r < (truth ? 65 : 70))
			return 8'(v);
		return 8'($urandom_range(255));
	endfunction

	// Drive receiver stalls and check each score word taken
	always @(posedge clk) begin
		m_tready <= ($urandom_range(99) >= idle_pct(idle_mode, 1'b0));
		if (arst_n && m_tvalid && m_tready) begin
			got_score.is_overall  = m_tuser;
			got_score.last_result = m_tlast;
			got_score.tp      = m_tdata[31:0];
			got_score.fp      = m_tdata[63:32];
			got_score.fn      = m_tdata[95:64];
			got_score.tn      = m_tdata[127:96];
			got_score.prec    = m_tdata[144:128];
			got_score.rec     = m_tdata[161:145];
			got_score.fm      = m_tdata[178:162];
			got_score.prec_ok = m_tdata[179];
			got_score.rec_ok  = m_tdata[180];
			got_score.f_ok    = m_tdata[181];
			if (expected_scores.size() == 0) begin
				$error("score word received with none expected");
				err_count++;
			end else begin
				want_score = expected_scores.pop_front();
				check_field("is_overall", 32'(want_score.is_overall), 32'(got_score.is_overall));
				check_field("last_result", 32'(want_score.last_result),
					32'(got_score.last_result));
				check_field("true_pos", want_score.tp, got_score.tp);
				check_field("false_pos", want_score.fp, got_score.fp);
				check_field("false_neg", want_score.fn, got_score.fn);
				check_field("true_neg", want_score.tn, got_score.tn);
				check_field("precision", 32'(want_score.prec), 32'(got_score.prec));
				check_field("recall", 32'(want_score.rec), 32'(got_score.rec));
				check_field("f_measure", 32'(want_score.fm), 32'(got_score.fm));
				check_field("precision_ok", 32'(want_score.prec_ok), 32'(got_score.prec_ok));
				check_field("recall_ok", 32'(want_score.rec_ok), 32'(got_score.rec_ok));
				check_field("f_ok", 32'(want_score.f_ok), 32'(got_score.f_ok));
			end
		end
	end

	// Watchdog
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("binary_map_f_measure_unit test failed");
			$finish;
		end
	end

	initial begin
		dir_row_t row;
		score_t typed_s;
		int thr_pick;
		logic [7:0] det;
		logic [7:0] tru;
		logic ie;
		logic be;

		dir_rows = '{
			// single-pixel batches right after reset, scores read off directly
			'{0, 127, 255, 255, 1, 1, 1, 1, 0, 0, 0, 65536, 65536, 65536, 1, 1, 1},
			'{0, 127, 0, 0, 1, 1, 1, 0, 0, 0, 1, 0, 0, 0, 0, 0, 0},
			'{0, 127, 255, 0, 1, 1, 1, 0, 1, 0, 0, 0, 0, 0, 1, 0, 0},
			'{0, 127, 0, 255, 1, 1, 1, 0, 0, 1, 0, 0, 0, 0, 0, 1, 0},
			// one of each class, then a batch end without an image end
			'{0, 127, 128, 255, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0},
			'{0, 127, 127, 200, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0},
			'{0, 127, 200, 254, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0},
			'{0, 127, 0, 255, 1, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0},
			'{0, 127, 255, 255, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0},
			'{0, 127, 255, 255, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0},
			'{0, 127, 0, 0, 0, 1, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0},
			// lowest threshold
			'{1, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0},
			'{0, 0, 1, 255, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0},
			'{0, 0, 0, 255, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0},
			'{0, 0, 255, 1, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0},
			'{0, 0, 1, 0, 1, 1, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0},
			// highest threshold: nothing is white; the last row lowers it to 254
			'{1, 255, 255, 255, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0},
			'{0, 255, 0, 255, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0},
			'{0, 255, 255, 254, 1, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0},
			'{0, 255, 0, 0, 1, 1, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0},
			'{1, 254, 255, 255, 1, 1, 1, 1, 0, 0, 0, 65536, 65536, 65536, 1, 1, 1}
		};

		// Hold reset, then check the threshold reset value
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		read_threshold(THRESHOLD_RESET);

		// Walk the directed table
		idle_mode <= IDLE_BOTH;
		for (int k = 0; k < NUM_DIR; k++) begin
			row = dir_rows[k];
			if (row.set_thr != 0)
				set_threshold(8'(row.thr_val));
			typed_s = '0;
			typed_s.tp      = 32'(row.tp);
			typed_s.fp      = 32'(row.fp);
			typed_s.fn      = 32'(row.fn);
			typed_s.tn      = 32'(row.tn);
			typed_s.prec    = 17'(row.prec);
			typed_s.rec     = 17'(row.rec);
			typed_s.fm      = 17'(row.fm);
			typed_s.prec_ok = (row.pok != 0);
			typed_s.rec_ok  = (row.rok != 0);
			typed_s.f_ok    = (row.fok != 0);
			send_pixel(8'(row.det), 8'(row.tru), row.img_end != 0, row.bat_end != 0,
				row.typed != 0, typed_s);
		end

		// Random images and batches, one threshold and idle pattern per phase
		typed_s = '0;
		for (int p = 0; p < NUM_PHASES; p++) begin
			if (p == 1)
				thr_pick = 0;
			else if (p == 2)
				thr_pick = 255;
			else if (p == 4)
				thr_pick = THRESHOLD_RESET;
			else
				thr_pick = $urandom_range(255);
			idle_mode <= idle_mode_t'(p % 4);
			set_threshold(8'(thr_pick));
			for (int k = 0; k < PHASE_WORDS; k++) begin
				if (k == PAUSE_AT)
					drain_results();
				det = pick_grey(thr_pick, 1'b0);
				tru = pick_grey(thr_pick, 1'b1);
				ie  = ($urandom_range(9) == 0);
				be  = ($urandom_range(29) == 0);
				send_pixel(det, tru, ie, be, 1'b0, typed_s);
			end
		end

		// Let the last words come back, then report
		drain_results();
		repeat (TAIL_CYCLES) @(posedge clk);
		if (err_count == 0 && expected_scores.size() == 0) begin
			$display("binary_map_f_measure_unit test passed");
		end else begin
			$display("binary_map_f_measure_unit test failed");
		end
		$finish;
	end

endmodule
`default_nettype wire

// ===== filelist.f =====
hdl/bmf_pkg.sv
hdl/bmf_front.sv
hdl/bmf_queue.sv
hdl/bmf_div.sv
hdl/bmf_back.sv
hdl/binary_map_f_measure_unit.sv
tb/tb_top.sv
